@@ sv/gbdt_pkg.sv @@
// ----------------------------------------------------------------------------
// gbdt_pkg
// Shared types and codes for the graph traversal block.
// ----------------------------------------------------------------------------
package gbdt_pkg;

    localparam int MAX_CITIES = 16;
    localparam int MAX_DEGREE = 16;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_DFS = 2'd1;
    localparam logic [1:0] OP_BFS = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_W1,
        S_ADD_W2,
        S_CLEAR,
        S_BFS_POP,
        S_BFS_SCAN,
        S_BFS_NB,
        S_DFS_ROOT,
        S_DFS_TOP,
        S_DFS_NB,
        S_EMIT
    } state_t;

endpackage

@@ sv/gbdt_ram.sv @@
// ----------------------------------------------------------------------------
// gbdt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbdt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/graph_bfs_dfs_traversal.sv @@
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// Undirected graph store with ordered adjacency lists and BFS/DFS walks.
// ----------------------------------------------------------------------------
// An add-route result is registered after the second adjacency write, or straight
// from the range or full check on an error. Walk steps wait on the registered memory reads.
// One request is processed at a time; the next is taken once all results left,
// and a stalled result holds the walk. Reset: rst_n asynchronously clears control
// state, degrees and visited marks, sets num_cities to 16; adjacency is not cleared.
module graph_bfs_dfs_traversal (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // opcode[1:0], city_a[5:2], city_b[9:6]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // city[3:0], status[5:4]
    output logic        m_axis_tlast
);

    localparam int MAX_CITIES = gbdt_pkg::MAX_CITIES;
    localparam int MAX_DEGREE = gbdt_pkg::MAX_DEGREE;
    localparam int CW = $clog2(MAX_CITIES);
    localparam int DW = $clog2(MAX_DEGREE);
    localparam int GW = $clog2(MAX_DEGREE + 1);
    localparam int NW = CW + DW;
    localparam int TW = CW + 1;
    localparam int LIM = (MAX_CITIES < 16) ? MAX_CITIES : 16;

    gbdt_pkg::state_t state_reg, state_next, ret_reg, ret_next;

    logic [4:0]  ncfg_reg;
    logic [4:0]  n_eff;
    logic [GW-1:0] deg_reg [MAX_CITIES];
    logic [MAX_CITIES-1:0] vis_reg, vis_next;

    // Work list (queue/stack) and per-level next index live in small
    // registered-read memories.
    logic          wl_we;
    logic [CW-1:0] wl_waddr, wl_raddr;
    logic [3:0]    wl_wdata, wl_rdata;
    logic          sn_we;
    logic [CW-1:0] sn_waddr, sn_raddr;
    logic [DW:0]   sn_wdata, sn_rdata;
    logic          nt_we;
    logic [NW-1:0] nt_waddr, nt_raddr;
    logic [3:0]    nt_wdata, nt_rdata;

    logic [3:0]  a_reg, a_next, b_reg, b_next;
    logic [TW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [4:0]  root_reg, root_next;
    logic [3:0]  cur_reg, cur_next;
    logic [DW:0] j_reg, j_next;

    // Output holding register, plus one-entry pending result used so the
    // last flag can be set once the walk knows no more results follow.
    logic        ov_reg, ov_next;
    logic [3:0]  oc_reg, oc_next;
    logic [1:0]  os_reg, os_next;
    logic        ol_reg, ol_next;
    logic        pv_reg, pv_next;
    logic [3:0]  pc_reg, pc_next;

    logic [CW-1:0] a_idx, b_idx, cur_idx;
    logic          deg_we0, deg_we1;

    assign n_eff   = (ncfg_reg > 5'(LIM)) ? 5'(LIM) : ncfg_reg;
    assign a_idx   = a_reg[CW-1:0];
    assign b_idx   = b_reg[CW-1:0];
    assign cur_idx = cur_reg[CW-1:0];

    assign cfg_ready     = (state_reg == gbdt_pkg::S_IDLE) && !ov_reg;
    assign s_axis_tready = (state_reg == gbdt_pkg::S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {2'b00, os_reg, oc_reg};
    assign m_axis_tlast  = ol_reg;

    gbdt_ram #(.WIDTH(4), .DEPTH(MAX_CITIES * MAX_DEGREE)) u_nt (
        .clk(clk), .we(nt_we), .waddr(nt_waddr), .wdata(nt_wdata),
        .raddr(nt_raddr), .rdata(nt_rdata));
    gbdt_ram #(.WIDTH(4), .DEPTH(MAX_CITIES)) u_wl (
        .clk(clk), .we(wl_we), .waddr(wl_waddr), .wdata(wl_wdata),
        .raddr(wl_raddr), .rdata(wl_rdata));
    gbdt_ram #(.WIDTH(DW + 1), .DEPTH(MAX_CITIES)) u_sn (
        .clk(clk), .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
        .raddr(sn_raddr), .rdata(sn_rdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbdt_pkg::S_IDLE;
            ret_reg   <= gbdt_pkg::S_IDLE;
            ncfg_reg  <= 5'd16;
            vis_reg   <= '0;
            ov_reg    <= 1'b0;
            pv_reg    <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            for (int i = 0; i < MAX_CITIES; i++)
            begin
                deg_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            vis_reg   <= vis_next;
            ov_reg    <= ov_next;
            pv_reg    <= pv_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (cfg_valid && cfg_ready)
            begin
                ncfg_reg <= cfg_data;
            end
            if (deg_we0)
            begin
                deg_reg[a_idx] <= deg_reg[a_idx] + 1'b1;
            end
            if (deg_we1)
            begin
                deg_reg[b_idx] <= deg_reg[b_idx] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        root_reg <= root_next;
        cur_reg  <= cur_next;
        j_reg    <= j_next;
        oc_reg   <= oc_next;
        os_reg   <= os_next;
        ol_reg   <= ol_next;
        pc_reg   <= pc_next;
    end

    always_comb
    begin
        logic [GW-1:0] da, db;
        logic [3:0]    nx;
        logic          take;
        logic          odone;
        state_next = state_reg;
        ret_next   = ret_reg;
        vis_next   = vis_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        root_next  = root_reg;
        cur_next   = cur_reg;
        j_next     = j_reg;
        pv_next    = pv_reg;
        pc_next    = pc_reg;
        odone      = ov_reg && m_axis_tready;
        ov_next    = ov_reg && !m_axis_tready;
        oc_next    = oc_reg;
        os_next    = os_reg;
        ol_next    = ol_reg;
        nt_we = 1'b0; nt_waddr = '0; nt_wdata = '0; nt_raddr = '0;
        wl_we = 1'b0; wl_waddr = '0; wl_wdata = '0; wl_raddr = '0;
        sn_we = 1'b0; sn_waddr = '0; sn_wdata = '0; sn_raddr = '0;
        deg_we0 = 1'b0; deg_we1 = 1'b0;
        da = deg_reg[a_idx];
        db = deg_reg[b_idx];
        nx = nt_rdata;
        take = 1'b0;
        unique case (state_reg)
            gbdt_pkg::S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    a_next  = s_axis_tdata[5:2];
                    b_next  = s_axis_tdata[9:6];
                    root_next = '0;
                    pv_next   = 1'b0;
                    unique case (s_axis_tdata[1:0])
                        gbdt_pkg::OP_ADD: state_next = gbdt_pkg::S_ADD_W1;
                        gbdt_pkg::OP_DFS: state_next = gbdt_pkg::S_DFS_ROOT;
                        gbdt_pkg::OP_BFS: state_next = gbdt_pkg::S_CLEAR;
                        default:          state_next = gbdt_pkg::S_IDLE;
                    endcase
                    if (s_axis_tdata[1:0] != gbdt_pkg::OP_ADD)
                    begin
                        vis_next = '0;
                    end
                end
            end
            gbdt_pkg::S_ADD_W1:
            begin
                ol_next = 1'b1;
                oc_next = '0;
                if ({1'b0, a_reg} >= n_eff || {1'b0, b_reg} >= n_eff)
                begin
                    os_next = gbdt_pkg::ST_RANGE;
                    ov_next = 1'b1;
                    state_next = gbdt_pkg::S_EMIT;
                end
                else if ((a_reg == b_reg && 32'(da) + 2 > MAX_DEGREE) ||
                         (a_reg != b_reg && (32'(da) >= MAX_DEGREE ||
                                             32'(db) >= MAX_DEGREE)))
                begin
                    os_next = gbdt_pkg::ST_FULL;
                    ov_next = 1'b1;
                    state_next = gbdt_pkg::S_EMIT;
                end
                else
                begin
                    nt_we    = 1'b1;
                    nt_waddr = {a_idx, da[DW-1:0]};
                    nt_wdata = b_reg;
                    deg_we0  = 1'b1;
                    state_next = gbdt_pkg::S_ADD_W2;
                end
            end
            gbdt_pkg::S_ADD_W2:
            begin
                nt_we    = 1'b1;
                nt_waddr = {b_idx, db[DW-1:0]};
                nt_wdata = a_reg;
                deg_we1  = 1'b1;
                os_next  = gbdt_pkg::ST_OK;
                oc_next  = '0;
                ol_next  = 1'b1;
                ov_next  = 1'b1;
                state_next = gbdt_pkg::S_EMIT;
            end
            gbdt_pkg::S_CLEAR:
            begin
                if ({1'b0, a_reg} >= n_eff)
                begin
                    oc_next = '0; os_next = gbdt_pkg::ST_RANGE;
                    ol_next = 1'b1; ov_next = 1'b1;
                    state_next = gbdt_pkg::S_EMIT;
                end
                else
                begin
                    wl_we = 1'b1; wl_waddr = '0; wl_wdata = a_reg;
                    vis_next[a_idx] = 1'b1;
                    head_next = '0;
                    tail_next = TW'(1);
                    state_next = gbdt_pkg::S_BFS_POP;
                end
            end
            gbdt_pkg::S_BFS_POP:
            begin
                // Issue work list read at head.
                if (head_reg == tail_reg)
                begin
                    state_next = gbdt_pkg::S_EMIT;
                    ret_next = gbdt_pkg::S_IDLE;
                end
                else
                begin
                    wl_raddr = head_reg[CW-1:0];
                    head_next = head_reg + 1'b1;
                    j_next = '0;
                    state_next = gbdt_pkg::S_BFS_SCAN;
                    ret_next = gbdt_pkg::S_BFS_SCAN;
                end
            end
            gbdt_pkg::S_BFS_SCAN:
            begin
                if (ret_reg == gbdt_pkg::S_BFS_SCAN)
                begin
                    cur_next = wl_rdata;
                    take = 1'b1;
                    pc_next = wl_rdata;
                    ret_next = gbdt_pkg::S_BFS_NB;
                end
                else if (32'(j_reg) >= 32'(deg_reg[cur_idx]) || 32'(j_reg) >= MAX_DEGREE)
                begin
                    state_next = gbdt_pkg::S_BFS_POP;
                end
                else
                begin
                    nt_raddr = {cur_idx, j_reg[DW-1:0]};
                    j_next = j_reg + 1'b1;
                    state_next = gbdt_pkg::S_BFS_NB;
                end
            end
            gbdt_pkg::S_BFS_NB:
            begin
                if ({1'b0, nx} < n_eff && !vis_reg[nx[CW-1:0]] &&
                    32'(tail_reg) < MAX_CITIES)
                begin
                    vis_next[nx[CW-1:0]] = 1'b1;
                    wl_we = 1'b1; wl_waddr = tail_reg[CW-1:0]; wl_wdata = nx;
                    tail_next = tail_reg + 1'b1;
                end
                state_next = gbdt_pkg::S_BFS_SCAN;
            end
            gbdt_pkg::S_DFS_ROOT:
            begin
                if (root_reg >= n_eff)
                begin
                    state_next = gbdt_pkg::S_EMIT;
                    ret_next = gbdt_pkg::S_IDLE;
                end
                else if (vis_reg[root_reg[CW-1:0]])
                begin
                    root_next = root_reg + 1'b1;
                end
                else
                begin
                    vis_next[root_reg[CW-1:0]] = 1'b1;
                    take = 1'b1;
                    pc_next = root_reg[3:0];
                    wl_we = 1'b1; wl_waddr = '0; wl_wdata = root_reg[3:0];
                    sn_we = 1'b1; sn_waddr = '0; sn_wdata = '0;
                    tail_next = TW'(1);
                    root_next = root_reg + 1'b1;
                    state_next = gbdt_pkg::S_DFS_TOP;
                    ret_next = gbdt_pkg::S_DFS_ROOT;
                end
            end
            gbdt_pkg::S_DFS_TOP:
            begin
                // Read top of stack; ret_reg tracks read vs. evaluate.
                if (tail_reg == '0)
                begin
                    state_next = gbdt_pkg::S_DFS_ROOT;
                end
                else if (ret_reg != gbdt_pkg::S_DFS_TOP)
                begin
                    wl_raddr = CW'(tail_reg - 1'b1);
                    sn_raddr = CW'(tail_reg - 1'b1);
                    ret_next = gbdt_pkg::S_DFS_TOP;
                end
                else
                begin
                    ret_next = gbdt_pkg::S_DFS_ROOT;
                    cur_next = wl_rdata;
                    if (32'(sn_rdata) >= 32'(deg_reg[wl_rdata[CW-1:0]]) ||
                        32'(sn_rdata) >= MAX_DEGREE)
                    begin
                        tail_next = tail_reg - 1'b1;
                    end
                    else
                    begin
                        // Keep the adjacency position so a stalled neighbor can be re-read.
                        j_next = sn_rdata;
                        sn_we = 1'b1; sn_waddr = CW'(tail_reg - 1'b1);
                        sn_wdata = sn_rdata + 1'b1;
                        nt_raddr = {wl_rdata[CW-1:0], sn_rdata[DW-1:0]};
                        state_next = gbdt_pkg::S_DFS_NB;
                    end
                end
            end
            gbdt_pkg::S_DFS_NB:
            begin
                if ({1'b0, nx} < n_eff && !vis_reg[nx[CW-1:0]] &&
                    32'(tail_reg) < MAX_CITIES)
                begin
                    if (ov_reg && !odone)
                    begin
                        // Hold until the output slot is free.
                        state_next = gbdt_pkg::S_DFS_NB;
                    end
                    else
                    begin
                        vis_next[nx[CW-1:0]] = 1'b1;
                        take = 1'b1;
                        pc_next = nx;
                        wl_we = 1'b1; wl_waddr = tail_reg[CW-1:0]; wl_wdata = nx;
                        sn_we = 1'b1; sn_waddr = tail_reg[CW-1:0]; sn_wdata = '0;
                        tail_next = tail_reg + 1'b1;
                        state_next = gbdt_pkg::S_DFS_TOP;
                    end
                end
                else
                begin
                    state_next = gbdt_pkg::S_DFS_TOP;
                end
                if (state_next == gbdt_pkg::S_DFS_NB)
                begin
                    nt_raddr = {cur_idx, j_reg[DW-1:0]};
                end
            end
            gbdt_pkg::S_EMIT:
            begin
                // Flush the pending result with last set, then return to idle.
                if (!ov_reg || odone)
                begin
                    if (pv_reg)
                    begin
                        ov_next = 1'b1; oc_next = pc_reg;
                        os_next = gbdt_pkg::ST_OK; ol_next = 1'b1;
                        pv_next = 1'b0;
                    end
                    state_next = gbdt_pkg::S_IDLE;
                    ret_next = gbdt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gbdt_pkg::S_IDLE;
            end
        endcase
        // A new visit pushes the previous pending city out as a non-last result.
        if (take)
        begin
            pv_next = 1'b1;
            if (pv_reg)
            begin
                if (ov_reg && !odone)
                begin
                    // Output still busy: stall this step.
                    state_next = state_reg;
                    ret_next   = ret_reg;
                    vis_next   = vis_reg;
                    head_next  = head_reg;
                    tail_next  = tail_reg;
                    root_next  = root_reg;
                    cur_next   = cur_reg;
                    pc_next    = pc_reg;
                    pv_next    = pv_reg;
                    wl_we = 1'b0; sn_we = 1'b0;
                    if (state_reg == gbdt_pkg::S_BFS_SCAN)
                    begin
                        wl_raddr = CW'(head_reg - 1'b1);
                    end
                    if (state_reg == gbdt_pkg::S_DFS_NB)
                    begin
                        nt_raddr = {cur_idx, j_reg[DW-1:0]};
                    end
                end
                else
                begin
                    ov_next = 1'b1; oc_next = pc_reg;
                    os_next = gbdt_pkg::ST_OK; ol_next = 1'b0;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == gbdt_pkg::S_IDLE && !ov_reg))
        else $error("request accepted while busy");
    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(tail_reg) <= MAX_CITIES)
        else $error("work list overflow");
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbdt_pkg::S_BFS_POP) |-> (head_reg <= tail_reg))
        else $error("queue head passed tail");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif

endmodule

@@ tb/sv/tb_graph_bfs_dfs_traversal.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_bfs_dfs_traversal
// Drives route, breadth-first and depth-first requests into the graph block
// and checks every result against a behavioral graph model kept here.
// ----------------------------------------------------------------------------
module tb_graph_bfs_dfs_traversal;

    typedef struct packed {
        logic [3:0] city;
        logic       last;
        logic [1:0] status;
    } visit_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    graph_bfs_dfs_traversal u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow graph used to predict the traversal order.
    logic [3:0] adj_list [16][16];
    logic [4:0] adj_degree [16] = '{default: 5'd0};
    logic [4:0] active_cities = 5'd16;

    visit_t      visits_due [$];
    logic [15:0] pending_requests [$];

    // Stimulus control shared between the initial block and the clocked blocks.
    logic quiet_phase;
    logic pause_sender;
    logic [4:0] cfg_value;
    int cfg_req_count = 0;
    int cfg_ack_count = 0;

    int mismatch_count = 0;
    int result_count = 0;
    int routes_sent = 0;
    int bfs_sent = 0;
    int dfs_sent = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    always #1 clk = ~clk;

    function automatic int limit_count();
        return (active_cities > 16) ? 16 : active_cities;
    endfunction

    // Appends the results of one request to the expectation queue.
    function automatic void predict_request(logic [15:0] req);
        logic [1:0] op;
        logic [3:0] ca;
        logic [3:0] cb;
        int n;
        int head;
        int tail;
        int depth;
        int c;
        int j;
        int nx;
        int produced;
        bit seen [16];
        int order [16];
        int next_pos [16];
        visit_t v;
        op = req[1:0];
        ca = req[5:2];
        cb = req[9:6];
        n = limit_count();
        produced = 0;
        if (op == gbdt_pkg::OP_ADD) begin
            v.city = 4'd0;
            v.last = 1'b1;
            if (ca >= n || cb >= n) begin
                v.status = gbdt_pkg::ST_RANGE;
            end
            else if ((ca == cb && adj_degree[ca] + 2 > 16) ||
                     (ca != cb && (adj_degree[ca] >= 16 || adj_degree[cb] >= 16))) begin
                v.status = gbdt_pkg::ST_FULL;
            end
            else begin
                adj_list[ca][adj_degree[ca]] = cb;
                adj_degree[ca] = adj_degree[ca] + 5'd1;
                adj_list[cb][adj_degree[cb]] = ca;
                adj_degree[cb] = adj_degree[cb] + 5'd1;
                v.status = gbdt_pkg::ST_OK;
            end
            visits_due.insert(visits_due.size(), v);
        end
        else if (op == gbdt_pkg::OP_BFS) begin
            if (ca >= n) begin
                v.city = 4'd0;
                v.last = 1'b1;
                v.status = gbdt_pkg::ST_RANGE;
                visits_due.insert(visits_due.size(), v);
            end
            else begin
                foreach (seen[i]) seen[i] = 1'b0;
                head = 0;
                tail = 1;
                order[0] = int'(ca);
                seen[ca] = 1'b1;
                while (head < tail) begin
                    c = order[head];
                    head++;
                    v.city = c[3:0];
                    v.last = 1'b0;
                    v.status = gbdt_pkg::ST_OK;
                    visits_due.insert(visits_due.size(), v);
                    for (j = 0; j < adj_degree[c]; j++) begin
                        nx = int'(adj_list[c][j]);
                        if (nx < n && !seen[nx] && tail < 16) begin
                            seen[nx] = 1'b1;
                            order[tail] = nx;
                            tail++;
                        end
                    end
                end
                visits_due[$].last = 1'b1;
            end
        end
        else if (op == gbdt_pkg::OP_DFS) begin
            foreach (seen[i]) seen[i] = 1'b0;
            for (int root = 0; root < n; root++) begin
                if (!seen[root]) begin
                    seen[root] = 1'b1;
                    v.city = root[3:0];
                    v.last = 1'b0;
                    v.status = gbdt_pkg::ST_OK;
                    visits_due.insert(visits_due.size(), v);
                    produced++;
                    order[0] = root;
                    next_pos[0] = 0;
                    depth = 1;
                    while (depth > 0) begin
                        c = order[depth - 1];
                        j = next_pos[depth - 1];
                        if (j >= adj_degree[c]) begin
                            depth--;
                        end
                        else begin
                            next_pos[depth - 1] = j + 1;
                            nx = int'(adj_list[c][j]);
                            if (nx < n && !seen[nx] && depth < 16) begin
                                seen[nx] = 1'b1;
                                v.city = nx[3:0];
                                visits_due.insert(visits_due.size(), v);
                                produced++;
                                order[depth] = nx;
                                next_pos[depth] = 0;
                                depth++;
                            end
                        end
                    end
                end
            end
            if (produced > 0) visits_due[$].last = 1'b1;
        end
    endfunction

    // Sender: takes requests from the pending queue, idling now and then.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'd0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(s_axis_tdata);
                case (s_axis_tdata[1:0])
                    gbdt_pkg::OP_ADD: routes_sent++;
                    gbdt_pkg::OP_BFS: bfs_sent++;
                    gbdt_pkg::OP_DFS: dfs_sent++;
                    default: ;
                endcase
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() > 0 && !pause_sender &&
                    (quiet_phase || $urandom_range(99) >= 9)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_requests.pop_front();
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Configuration writes are requested by the initial block only while idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_valid     <= 1'b0;
            cfg_data      <= 5'd0;
            active_cities <= 5'd16;
        end
        else if (cfg_valid && cfg_ready) begin
            active_cities <= cfg_data;
            cfg_valid     <= 1'b0;
            cfg_ack_count <= cfg_ack_count + 1;
        end
        else if (cfg_req_count != cfg_ack_count && !cfg_valid) begin
            cfg_valid <= 1'b1;
            cfg_data  <= cfg_value;
        end
    end

    // Receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin
        visit_t seen_v;
        visit_t want;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_v.city   = m_axis_tdata[3:0];
                seen_v.status = m_axis_tdata[5:4];
                seen_v.last   = m_axis_tlast;
                result_count++;
                if (visits_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result city=%0d last=%0b status=%0d",
                                 seen_v.city, seen_v.last, seen_v.status);
                end
                else begin
                    want = visits_due.pop_front();
                    if (want != seen_v) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp city=%0d last=%0b status=%0d, ",
                                      "got city=%0d last=%0b status=%0d"},
                                     want.city, want.last, want.status,
                                     seen_v.city, seen_v.last, seen_v.status);
                    end
                end
            end
            m_axis_tready <= quiet_phase || ($urandom_range(99) >= 9);
        end
    end

    // Watchdog on cycles with no accepted request, configuration write or result.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            timed_out = 1'b1;
        end
    end

    task automatic queue_request(logic [1:0] op, logic [3:0] ca, logic [3:0] cb);
        pending_requests.insert(pending_requests.size(), {6'd0, cb, ca, op});
    endtask

    // Waits until the block has drained, then lets it settle.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_requests.size() > 0 || s_axis_tvalid || visits_due.size() > 0)
            @(negedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_city_count(logic [4:0] value);
        wait_drained();
        cfg_value = value;
        cfg_req_count++;
        while (cfg_ack_count != cfg_req_count) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int pick;
        int lim;
        lim = (limit_count() == 0) ? 1 : limit_count();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                queue_request(gbdt_pkg::OP_ADD, 4'($urandom_range(lim - 1)),
                              4'($urandom_range(lim - 1)));
            else if (pick < 80)
                queue_request(gbdt_pkg::OP_ADD, 4'($urandom_range(15)),
                              4'($urandom_range(15)));
            else if (pick < 88)
                queue_request(gbdt_pkg::OP_BFS, 4'($urandom_range(15)),
                              4'($urandom_range(15)));
            else if (pick < 96)
                queue_request(gbdt_pkg::OP_DFS, 4'($urandom_range(15)),
                              4'($urandom_range(15)));
            else
                queue_request(2'd3, 4'($urandom_range(15)), 4'($urandom_range(15)));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        quiet_phase = 1'b0;
        pause_sender = 1'b0;
        cfg_value = 5'd16;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty traversals, extremes, self loops, full lists.
        queue_request(gbdt_pkg::OP_DFS, 4'd0, 4'd0);
        queue_request(gbdt_pkg::OP_BFS, 4'd15, 4'd15);
        queue_request(gbdt_pkg::OP_ADD, 4'd0, 4'd15);
        queue_request(gbdt_pkg::OP_ADD, 4'd15, 4'd15);
        queue_request(gbdt_pkg::OP_ADD, 4'd3, 4'd3);
        queue_request(gbdt_pkg::OP_ADD, 4'd0, 4'd5);
        queue_request(gbdt_pkg::OP_ADD, 4'd0, 4'd5);
        queue_request(gbdt_pkg::OP_ADD, 4'd5, 4'd10);
        queue_request(2'd3, 4'd15, 4'd15);
        queue_request(gbdt_pkg::OP_BFS, 4'd0, 4'd0);
        queue_request(gbdt_pkg::OP_DFS, 4'd0, 4'd0);
        for (int i = 0; i < 7; i++) queue_request(gbdt_pkg::OP_ADD, 4'd7, 4'd7);
        queue_request(gbdt_pkg::OP_ADD, 4'd7, 4'd8);
        queue_request(gbdt_pkg::OP_ADD, 4'd7, 4'd8);
        queue_request(gbdt_pkg::OP_BFS, 4'd7, 4'd0);

        wait_drained();

        write_city_count(5'd6);
        queue_request(gbdt_pkg::OP_ADD, 4'd6, 4'd1);
        queue_request(gbdt_pkg::OP_BFS, 4'd6, 4'd0);
        queue_request(gbdt_pkg::OP_BFS, 4'd0, 4'd0);
        queue_request(gbdt_pkg::OP_DFS, 4'd0, 4'd0);

        write_city_count(5'd0);
        queue_request(gbdt_pkg::OP_DFS, 4'd0, 4'd0);
        queue_request(gbdt_pkg::OP_BFS, 4'd0, 4'd0);
        queue_request(gbdt_pkg::OP_ADD, 4'd0, 4'd0);

        write_city_count(5'd1);
        queue_request(gbdt_pkg::OP_ADD, 4'd0, 4'd0);
        queue_request(gbdt_pkg::OP_DFS, 4'd0, 4'd0);
        write_city_count(5'd31);
        queue_request(gbdt_pkg::OP_DFS, 4'd0, 4'd0);

        // Random part, with a quiet stretch where neither side idles.
        write_city_count(5'd16);
        random_phase(25);

        // Hold the sender mid-stream until every expected result has come back.
        while (pending_requests.size() > 10) @(posedge clk);
        pause_sender = 1'b1;
        @(negedge clk);
        while (s_axis_tvalid || visits_due.size() > 0) @(negedge clk);
        pause_sender = 1'b0;

        wait_drained();
        quiet_phase = 1'b1;
        random_phase(15);
        wait_drained();
        quiet_phase = 1'b0;
        write_city_count(5'd9);
        random_phase(20);
        write_city_count(5'd16);
        random_phase(10);
        wait_drained();

        $display("Sent %0d route, %0d breadth-first and %0d depth-first requests;",
                 routes_sent, bfs_sent, dfs_sent);
        $display("checked %0d results over city counts 0, 1, 6, 9, 16 and 31.", result_count);
        if (mismatch_count == 0 && !timed_out && visits_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("watchdog expired with %0d results outstanding", visits_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ graph_bfs_dfs_traversal.f @@
sv/gbdt_pkg.sv
sv/gbdt_ram.sv
sv/graph_bfs_dfs_traversal.sv
tb/sv/tb_graph_bfs_dfs_traversal.sv
